// ===== hw/rtl/dosn_pkg.sv =====
// Shared constants, widths and controller/datapath interface types
// for the difference-over-sum normalizer. No dependencies.
package dosn_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int MAX_FRAME   = 255;
   localparam int CNT_BITS    = $clog2(MAX_FRAME + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS;
   localparam int TOTAL_BITS  = SUM_BITS + 1;
   localparam int LEVEL_BITS  = 12;
   localparam int LIMIT_BITS  = CNT_BITS + LEVEL_BITS;
   localparam int NORM_BITS   = 12;
   localparam int QUO_BITS    = NORM_BITS - 1;
   localparam int NUM_BITS    = TOTAL_BITS + QUO_BITS - 1;
   localparam int STEP_BITS   = $clog2(QUO_BITS);
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = (CNT_BITS > LEVEL_BITS) ? CNT_BITS : LEVEL_BITS;

   localparam logic [QUO_BITS-1:0]   NORM_SCALE         = '1;
   localparam logic [CNT_BITS-1:0]   SAMPLE_COUNT_RESET = CNT_BITS'(10);
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET        = LEVEL_BITS'(600);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVEL        = 1'd1;

   typedef struct packed {
      logic acc;     // add request samples, count pair
      logic prep;    // capture total, magnitude, threshold; restart frame
      logic mul;     // scale magnitude, load divider
      logic step;    // one quotient bit
      logic finish;  // load response register
   } dp_cmd_type;

   typedef struct packed {
      logic last_pair;
      logic pass;
   } dp_status_type;

endpackage

// ===== hw/rtl/dosn_datapath.sv =====
// Datapath: configuration registers, channel sums, threshold check,
// restoring divider and held response. Depends on dosn_pkg.
module dosn_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dosn_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dosn_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [dosn_pkg::SAMPLE_BITS-1:0]   sample_a,
   input  logic [dosn_pkg::SAMPLE_BITS-1:0]   sample_b,
   input  dosn_pkg::dp_cmd_type               cmd,
   output dosn_pkg::dp_status_type            status,
   output logic signed [dosn_pkg::NORM_BITS-1:0] norm_value,
   output logic                              updated
);
   import dosn_pkg::*;

   logic [CNT_BITS-1:0]   sc_ff, sc_in;
   logic [LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic [SUM_BITS-1:0]   sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [SUM_BITS-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  pass_ff, pass_in;
   logic [NUM_BITS-1:0]   rem_ff, rem_in, dsr_ff, dsr_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [NORM_BITS-1:0]  held_ff, held_in;
   logic                  upd_ff, upd_in;

   logic [CNT_BITS-1:0]   eff_n;
   logic [LIMIT_BITS-1:0] limit;
   logic [NORM_BITS-1:0]  quo_ext;

   always_comb begin
      if (sc_ff == '0) begin
         eff_n = CNT_BITS'(1);
      end else if (sc_ff > CNT_BITS'(MAX_FRAME)) begin
         eff_n = CNT_BITS'(MAX_FRAME);
      end else begin
         eff_n = sc_ff;
      end
   end

   assign status.last_pair = ({1'b0, cnt_ff} + (CNT_BITS+1)'(1)) >= {1'b0, eff_n};
   assign status.pass      = pass_ff;

   assign limit   = LIMIT_BITS'(eff_n) * LIMIT_BITS'(lvl_ff);
   assign quo_ext = {1'b0, quo_ff};

   always_comb begin
      sc_in    = sc_ff;
      lvl_in   = lvl_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      pass_in  = pass_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      held_in  = held_ff;
      upd_in   = upd_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: sc_in  = csr_wdata[CNT_BITS-1:0];
            CSR_LEVEL:        lvl_in = csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end

      if (cmd.acc) begin
         sum_a_in = sum_a_ff + SUM_BITS'(sample_a);
         sum_b_in = sum_b_ff + SUM_BITS'(sample_b);
         cnt_in   = cnt_ff + CNT_BITS'(1);
      end

      if (cmd.prep) begin
         total_in = TOTAL_BITS'(sum_a_ff) + TOTAL_BITS'(sum_b_ff);
         neg_in   = sum_a_ff < sum_b_ff;
         mag_in   = (sum_a_ff < sum_b_ff) ? sum_b_ff - sum_a_ff : sum_a_ff - sum_b_ff;
         pass_in  = total_in > TOTAL_BITS'(limit);
         sum_a_in = '0;
         sum_b_in = '0;
         cnt_in   = '0;
      end

      if (cmd.mul) begin
         rem_in = NUM_BITS'(mag_ff) * NUM_BITS'(NORM_SCALE);
         dsr_in = NUM_BITS'(total_ff) << (QUO_BITS - 1);
         quo_in = '0;
      end

      if (cmd.step) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         dsr_in = dsr_ff >> 1;
      end

      if (cmd.finish) begin
         upd_in = pass_ff;
         if (pass_ff) begin
            held_in = neg_ff ? NORM_BITS'(-quo_ext) : quo_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff    <= SAMPLE_COUNT_RESET;
         lvl_ff   <= LEVEL_RESET;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         cnt_ff   <= '0;
         held_ff  <= '0;
         pass_ff  <= 1'b0;
         upd_ff   <= 1'b0;
      end else begin
         sc_ff    <= sc_in;
         lvl_ff   <= lvl_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         cnt_ff   <= cnt_in;
         held_ff  <= held_in;
         pass_ff  <= pass_in;
         upd_ff   <= upd_in;
      end
      total_ff <= total_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
   end

   assign norm_value = held_ff;
   assign updated    = upd_ff;

endmodule

// ===== hw/rtl/dosn_controller.sv =====
// Controller: sequences accumulation, frame-end check, division and
// response handshake. Depends on dosn_pkg.
module dosn_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dosn_pkg::dp_status_type status,
   output dosn_pkg::dp_cmd_type    cmd
);
   import dosn_pkg::*;

   typedef enum logic [2:0] {IDLE, PREP, MUL, DIV, DONE} state_type;

   state_type            state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 rsp_valid_ff;
   logic                 req_fire;

   // a frame end may only start once the response register is free
   assign req_ready = (state_ff == IDLE) && !(status.last_pair && rsp_valid_ff);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.acc    = req_fire;
      cmd.prep   = (state_ff == PREP);
      cmd.mul    = (state_ff == MUL);
      cmd.step   = (state_ff == DIV);
      cmd.finish = (state_ff == DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire && status.last_pair) begin
                  state_ff <= PREP;
               end
            end
            PREP: begin
               state_ff <= MUL;
            end
            MUL: begin
               step_ff  <= STEP_BITS'(QUO_BITS - 1);
               state_ff <= status.pass ? DIV : DONE;
            end
            DIV: begin
               step_ff <= step_ff - STEP_BITS'(1);
               if (step_ff == '0) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/difference_over_sum_normalizer.sv =====
// Top level of the difference-over-sum normalizer.
// Instantiates dosn_controller and dosn_datapath; depends on dosn_pkg.
//
// Each request carries one sample pair. The pair that closes a frame (sample_count
// pairs, zero read as one) starts the frame-end sequence: PREP forms the total,
// difference magnitude and threshold test, MUL does the 2047 scaling multiply,
// DIV runs the restoring divider (one quotient bit a cycle, skipped when the
// threshold fails) and DONE loads the response register; no request is taken
// until the sequence is back in IDLE.
// Only frame-closing requests wait for the response register to empty; all
// other pairs are taken while a response is pending.
module difference_over_sum_normalizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dosn_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [dosn_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dosn_pkg::SAMPLE_BITS-1:0]      req_sample_a,
   input  logic [dosn_pkg::SAMPLE_BITS-1:0]      req_sample_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dosn_pkg::NORM_BITS-1:0] rsp_norm_value,
   output logic                                  rsp_updated
);
   import dosn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   dosn_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dosn_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample_a   (req_sample_a),
      .sample_b   (req_sample_b),
      .cmd        (cmd),
      .status     (status),
      .norm_value (rsp_norm_value),
      .updated    (rsp_updated)
   );

endmodule

// ===== tb/difference_over_sum_normalizer_test.sv =====
// Self-checking testbench for difference_over_sum_normalizer: directed table, then
// randomized frames under many frame-length/threshold settings, random flow control.
// Depends on dosn_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module difference_over_sum_normalizer_test;
   import dosn_pkg::*;

   localparam int     RANDOM_PAIRS    = 1000;
   localparam int     SETTLE_CYCLES   = 20;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     QUIET_LIMIT     = 4000;
   localparam longint FULL_SCALE      = 2047;

   typedef enum logic {ROW_CSR, ROW_PAIR} row_kind_type;

   typedef struct packed {
      logic [NORM_BITS-1:0] norm;
      logic                 updated;
   } norm_result_type;

   // CSR rows: x = register index, y = write data
   typedef struct packed {
      row_kind_type           kind;
      logic [SAMPLE_BITS-1:0] x;
      logic [SAMPLE_BITS-1:0] y;
      logic                   typed;
      norm_result_type        result;
   } dir_row_type;

   localparam int DIRECTED_ROWS = 25;

   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CSR,  12'(CSR_SAMPLE_COUNT), 12'hF01, 1'b0, '{12'd0, 1'b0}},
      '{ROW_CSR,  12'(CSR_LEVEL),        12'd0,   1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'h000, 12'h000, 1'b1, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'hFFF, 12'h000, 1'b1, '{12'd2047, 1'b1}},
      '{ROW_PAIR, 12'h000, 12'hFFF, 1'b1, '{-12'sd2047, 1'b1}},
      '{ROW_PAIR, 12'h000, 12'h000, 1'b1, '{-12'sd2047, 1'b0}},
      '{ROW_PAIR, 12'hFFF, 12'hFFF, 1'b1, '{12'd0, 1'b1}},
      '{ROW_CSR,  12'(CSR_LEVEL),        12'hFFF, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'hFFF, 12'h000, 1'b1, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'hFFF, 12'h001, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'h001, 12'hFFF, 1'b0, '{12'd0, 1'b0}},
      '{ROW_CSR,  12'(CSR_SAMPLE_COUNT), 12'h700, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'h800, 12'h800, 1'b1, '{12'd0, 1'b1}},
      '{ROW_PAIR, 12'hFFF, 12'h800, 1'b0, '{12'd0, 1'b0}},
      '{ROW_CSR,  12'(CSR_LEVEL),        12'd600, 1'b0, '{12'd0, 1'b0}},
      '{ROW_CSR,  12'(CSR_SAMPLE_COUNT), 12'd3,   1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd1000, 12'd200, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd3000, 12'd0,   1'b0, '{12'd0, 1'b0}},
      // frame length lowered below the pairs already taken
      '{ROW_CSR,  12'(CSR_SAMPLE_COUNT), 12'd1,   1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd5,    12'd700, 1'b0, '{12'd0, 1'b0}},
      '{ROW_CSR,  12'(CSR_SAMPLE_COUNT), 12'd2,   1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'hFFF,  12'h000, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd2730, 12'd1365, 1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd1,    12'd2,   1'b0, '{12'd0, 1'b0}},
      '{ROW_PAIR, 12'd3,    12'd4,   1'b0, '{12'd0, 1'b0}}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SAMPLE_BITS-1:0]   req_sample_a = '0;
   logic [SAMPLE_BITS-1:0]   req_sample_b = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [NORM_BITS-1:0] rsp_norm_value;
   logic                     rsp_updated;

   // predictor state and register copies
   logic [CNT_BITS-1:0]   frame_len_cfg = SAMPLE_COUNT_RESET;
   logic [LEVEL_BITS-1:0] level_cfg = LEVEL_RESET;
   logic [SUM_BITS-1:0]   sum_a_acc = '0;
   logic [SUM_BITS-1:0]   sum_b_acc = '0;
   logic [CNT_BITS-1:0]   pairs_in_frame = '0;
   logic [NORM_BITS-1:0]  held_norm_value = '0;

   norm_result_type pending_norms [$];

   int  failures = 0;
   int  pairs_sent = 0;
   int  results_checked = 0;
   int  updates_seen = 0;
   int  quiet_cycles = 0;
   bit  hold_off_phase = 1'b0;

   difference_over_sum_normalizer uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_a   (req_sample_a),
      .req_sample_b   (req_sample_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_norm_value (rsp_norm_value),
      .rsp_updated    (rsp_updated)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Adds one pair to the frame; returns 1 when the pair closes the frame.
   function automatic bit accumulate_pair(input logic [SAMPLE_BITS-1:0] a,
                                          input logic [SAMPLE_BITS-1:0] b,
                                          output norm_result_type res);
      logic [CNT_BITS:0]     frame_len;
      logic [TOTAL_BITS-1:0] total;
      logic [LIMIT_BITS-1:0] limit;
      longint                diff;
      longint                quot;
      frame_len = (frame_len_cfg == '0) ? (CNT_BITS+1)'(1) : {1'b0, frame_len_cfg};
      sum_a_acc = sum_a_acc + SUM_BITS'(a);
      sum_b_acc = sum_b_acc + SUM_BITS'(b);
      pairs_in_frame = pairs_in_frame + CNT_BITS'(1);
      res = '0;
      if ({1'b0, pairs_in_frame} < frame_len)
         return 1'b0;
      total = TOTAL_BITS'(sum_a_acc) + TOTAL_BITS'(sum_b_acc);
      limit = LIMIT_BITS'(frame_len) * LIMIT_BITS'(level_cfg);
      if (total > TOTAL_BITS'(limit)) begin
         diff = longint'(sum_a_acc) - longint'(sum_b_acc);
         quot = (FULL_SCALE * diff) / longint'(total);
         held_norm_value = quot[NORM_BITS-1:0];
         res.updated = 1'b1;
      end
      res.norm = held_norm_value;
      sum_a_acc = '0;
      sum_b_acc = '0;
      pairs_in_frame = '0;
      return 1'b1;
   endfunction

   task automatic send_pair(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
                            input logic typed, input norm_result_type typed_res);
      norm_result_type res;
      req_valid <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      do @(posedge clock); while (!req_ready);
      pairs_sent++;
      if (accumulate_pair(a, b, res))
         pending_norms.push_back(typed ? typed_res : res);
   endtask

   task automatic idle_between();
      int gap;
      if ($urandom_range(0, 1) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_norms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      wait_until_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SAMPLE_COUNT)
         frame_len_cfg = data[CNT_BITS-1:0];
      else
         level_cfg = data[LEVEL_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic draw_pair(output logic [SAMPLE_BITS-1:0] a, output logic [SAMPLE_BITS-1:0] b);
      int mode;
      mode = $urandom_range(0, 9);
      case (mode)
         0: begin
            a = '0;
            b = '0;
         end
         1: begin
            a = $urandom_range(0, 1) ? '1 : '0;
            b = $urandom_range(0, 1) ? '1 : '0;
         end
         2, 3: begin
            a = SAMPLE_BITS'($urandom_range(0, 63));
            b = SAMPLE_BITS'($urandom_range(0, 63));
         end
         default: begin
            a = SAMPLE_BITS'($urandom_range(0, 4095));
            b = SAMPLE_BITS'($urandom_range(0, 4095));
         end
      endcase
   endtask

   // response checker
   always @(posedge clock) begin
      norm_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_updated === 1'b1)
            updates_seen++;
         if (pending_norms.size() == 0) begin
            $error("unexpected response: norm_value %0d updated %0b", rsp_norm_value, rsp_updated);
            failures++;
         end else begin
            want = pending_norms.pop_front();
            if (rsp_norm_value !== want.norm) begin
               $error("norm_value: expected %0d, got %0d", $signed(want.norm), rsp_norm_value);
               failures++;
            end
            if (rsp_updated !== want.updated) begin
               $error("updated: expected %0b, got %0b", want.updated, rsp_updated);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // response side flow control
   initial begin
      bit held_off;
      int run;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_phase && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   initial begin
      logic [SAMPLE_BITS-1:0]   a;
      logic [SAMPLE_BITS-1:0]   b;
      logic [CSR_DATA_BITS-1:0] count_data;
      logic [CSR_DATA_BITS-1:0] level_data;
      int phase;
      int phase_len;
      int random_pairs;
      phase = 0;
      random_pairs = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_csr(directed_rows[i].x[CSR_IDX_BITS-1:0], directed_rows[i].y);
         end else begin
            send_pair(directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].typed, directed_rows[i].result);
            idle_between();
         end
      end

      while (random_pairs < RANDOM_PAIRS) begin
         count_data = {4'($urandom_range(0, 15)), 8'($urandom_range(1, 8))};
         level_data = CSR_DATA_BITS'($urandom_range(0, 4095));
         phase_len = $urandom_range(20, 80);
         case (phase)
            0: begin
               count_data = 12'd255;
               level_data = '0;
               phase_len = 260;
            end
            1: begin
               count_data = 12'd1;
               level_data = '1;
               phase_len = 60;
            end
            2: count_data = 12'hA00;
            default: begin
               case ($urandom_range(0, 9))
                  0: count_data[7:0] = '0;
                  1, 2: count_data[7:0] = 8'($urandom_range(9, 32));
                  default: ;
               endcase
               case ($urandom_range(0, 6))
                  0: level_data = '0;
                  1: level_data = '1;
                  default: ;
               endcase
            end
         endcase
         write_csr(CSR_SAMPLE_COUNT, count_data);
         write_csr(CSR_LEVEL, level_data);
         if (phase == 1)
            hold_off_phase = 1'b1;
         repeat (phase_len) begin
            draw_pair(a, b);
            send_pair(a, b, 1'b0, '0);
            random_pairs++;
            idle_between();
         end
         phase++;
      end

      wait_until_drained();
      $display("%0d sample pairs over %0d register settings, %0d frame results checked",
               pairs_sent, phase, results_checked);
      $display("%0d frames updated the output, %0d held it", updates_seen,
               results_checked - updates_seen);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
